// ----- design/dfrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfrc_pkg: shared types and constants of the DAC frame ramp controller
// Command kinds, sequencer states, register indexes and frame layout values.
// ----------------------------------------------------------------------------
package dfrc_pkg;

  localparam int CODE_W   = 12;
  localparam int WORD_W   = 16;
  localparam int PROD_W   = 28;
  localparam int DIV_STEPS = 12;
  localparam int CNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic [CODE_W-1:0] CODE_MAX   = 12'd4095;
  localparam logic [CODE_W-1:0] VMAP_LOW   = 12'd729;
  localparam logic [CODE_W-1:0] VMAP_HIGH  = 12'd3649;
  localparam logic [CODE_W-1:0] VMAP_SPAN  = 12'd2920;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_PD_1K  = 2'd1;

  localparam logic [CODE_W-1:0] RAMP_STEP_RESET = 12'd16;
  localparam logic [WORD_W-1:0] VREF_RESET      = 16'd3300;

  typedef enum logic [2:0] {
    KIND_SET_VALUE   = 3'd0,
    KIND_SET_VOLTAGE = 3'd1,
    KIND_RAMP_TARGET = 3'd2,
    KIND_TICK        = 3'd3,
    KIND_POWER_DOWN  = 3'd4,
    KIND_POWER_UP    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    CFG_RAMP_STEP  = 2'd0,
    CFG_VREF_LEVEL = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

// ----- design/dfrc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfrc_div: restoring divider, one quotient bit per cycle
// Divides a product by the reference level; the quotient is known to fit in
// the code width, so the upper product bits seed the partial remainder.
// ----------------------------------------------------------------------------
module dfrc_div (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  input  wire [dfrc_pkg::PROD_W-1:0]     dividend,
  input  wire [dfrc_pkg::WORD_W-1:0]     divisor,
  output logic                           done,
  output logic [dfrc_pkg::CODE_W-1:0]    quotient
);

  logic [dfrc_pkg::WORD_W-1:0] rem;
  logic [dfrc_pkg::CNT_W-1:0]  count;
  logic [dfrc_pkg::WORD_W:0]   trial;
  logic [dfrc_pkg::WORD_W:0]   diff;

  assign trial = {rem, quotient[dfrc_pkg::CODE_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= dfrc_pkg::CNT_W'(dfrc_pkg::DIV_STEPS);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == dfrc_pkg::CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // shift one dividend bit in, keep the difference when it does not go negative
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[dfrc_pkg::PROD_W-1:dfrc_pkg::CODE_W];
      quotient <= dividend[dfrc_pkg::CODE_W-1:0];
    end else if (count != '0) begin
      if (!diff[dfrc_pkg::WORD_W]) begin
        rem <= diff[dfrc_pkg::WORD_W-1:0];
      end else begin
        rem <= trial[dfrc_pkg::WORD_W-1:0];
      end
      quotient <= {quotient[dfrc_pkg::CODE_W-2:0], ~diff[dfrc_pkg::WORD_W]};
    end
  end

endmodule
`default_nettype wire

// ----- design/dac_frame_ramp_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sequence: every kind but set voltage goes from IDLE straight to FINISH; set voltage
//   with 0 < voltage < vref_level passes DIV_START and DIV (the serial divider) first.
// One item at a time: the next input beat is taken once the previous result sits
//   in the output register; FINISH holds while the result side stalls.
// Reset: synchronous; code 0, no ramp, powered up, ramp_step 16, vref_level 3300.
// ----------------------------------------------------------------------------
// dac_frame_ramp_controller: command front end for a 12-bit serial DAC
// Builds 16-bit DAC frames (mode 15:14, code 13:2) from value, voltage, ramp
// and power commands. The voltage map runs through a serial divider.
// ----------------------------------------------------------------------------
module dac_frame_ramp_controller (
  input  wire         clk,
  input  wire         rst,
  // command channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  kind,
  input  wire  [15:0] value,
  input  wire  [15:0] voltage,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic        frame_valid,
  output logic [15:0] frame_word,
  output logic [11:0] dac_code,
  output logic        status,
  output logic        ramp_busy,
  // register write channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  // configuration registers
  logic [dfrc_pkg::CODE_W-1:0] ramp_step;
  logic [dfrc_pkg::WORD_W-1:0] vref_level;

  // architectural state
  logic [dfrc_pkg::CODE_W-1:0] last_code, last_code_next;
  logic [dfrc_pkg::CODE_W-1:0] ramp_goal, ramp_goal_next;
  logic                        ramp_active, ramp_active_next;
  logic                        powered_down, powered_down_next;

  // latched command
  logic [2:0]                  cmd_kind;
  logic [dfrc_pkg::WORD_W-1:0] cmd_value;
  logic [dfrc_pkg::WORD_W-1:0] cmd_voltage;
  logic [dfrc_pkg::PROD_W-1:0] prod;

  dfrc_pkg::state_t state, state_next;
  logic                        div_start;
  logic                        div_done;
  logic [dfrc_pkg::CODE_W-1:0] quotient;

  logic in_fire;
  logic out_free;
  logic need_div;

  // result of the finishing cycle
  logic                        res_frame_valid;
  logic [1:0]                  res_mode;
  logic [dfrc_pkg::CODE_W-1:0] res_code;
  logic                        res_status;

  logic [dfrc_pkg::CODE_W-1:0] sat_value;
  logic [dfrc_pkg::CODE_W-1:0] step_eff;
  logic [dfrc_pkg::CODE_W-1:0] ramp_diff;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // only the interior of the voltage range needs the divider
  assign need_div = (kind == dfrc_pkg::KIND_SET_VOLTAGE) && (voltage != '0) &&
                    (voltage < vref_level);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step  <= dfrc_pkg::RAMP_STEP_RESET;
      vref_level <= dfrc_pkg::VREF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dfrc_pkg::CFG_RAMP_STEP:  ramp_step  <= cfg_data[dfrc_pkg::CODE_W-1:0];
        dfrc_pkg::CFG_VREF_LEVEL: vref_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfrc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dfrc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = need_div ? dfrc_pkg::ST_DIV_START : dfrc_pkg::ST_FINISH;
        end
      end
      dfrc_pkg::ST_DIV_START: state_next = dfrc_pkg::ST_DIV;
      dfrc_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = dfrc_pkg::ST_FINISH;
        end
      end
      dfrc_pkg::ST_FINISH: begin
        // hold until the output register can take the result
        if (out_free) begin
          state_next = dfrc_pkg::ST_IDLE;
        end
      end
      default: state_next = dfrc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    case (state)
      dfrc_pkg::ST_IDLE:      in_ready  = 1'b1;
      dfrc_pkg::ST_DIV_START: div_start = 1'b1;
      default: ;
    endcase
  end

  // latch the command; the product is registered before it feeds the divider
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_kind    <= kind;
      cmd_value   <= value;
      cmd_voltage <= voltage;
      prod        <= dfrc_pkg::PROD_W'(voltage) * dfrc_pkg::PROD_W'(dfrc_pkg::VMAP_SPAN);
    end
  end

  dfrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (vref_level),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------------------------------------------------------- command decode
  assign sat_value = (cmd_value > dfrc_pkg::WORD_W'(dfrc_pkg::CODE_MAX)) ?
                     dfrc_pkg::CODE_MAX : cmd_value[dfrc_pkg::CODE_W-1:0];
  assign step_eff  = (ramp_step == '0) ? dfrc_pkg::CODE_W'(1) : ramp_step;
  assign ramp_diff = (ramp_goal > last_code) ? (ramp_goal - last_code)
                                             : (last_code - ramp_goal);

  always_comb begin
    last_code_next    = last_code;
    ramp_goal_next    = ramp_goal;
    ramp_active_next  = ramp_active;
    powered_down_next = powered_down;
    res_frame_valid   = 1'b0;
    res_mode          = dfrc_pkg::MODE_NORMAL;
    res_code          = last_code;
    res_status        = 1'b0;
    case (cmd_kind)
      dfrc_pkg::KIND_SET_VALUE: begin
        res_frame_valid   = 1'b1;
        res_code          = sat_value;
        last_code_next    = sat_value;
        ramp_active_next  = 1'b0;
        powered_down_next = 1'b0;
      end
      dfrc_pkg::KIND_SET_VOLTAGE: begin
        if (cmd_voltage > vref_level) begin
          // reject: no frame, state untouched
          res_status = 1'b1;
        end else begin
          if (cmd_voltage == '0) begin
            res_code = dfrc_pkg::VMAP_LOW;
          end else if (cmd_voltage == vref_level) begin
            res_code = dfrc_pkg::VMAP_HIGH;
          end else begin
            res_code = dfrc_pkg::VMAP_LOW + quotient;
          end
          res_frame_valid   = 1'b1;
          last_code_next    = res_code;
          ramp_active_next  = 1'b0;
          powered_down_next = 1'b0;
        end
      end
      dfrc_pkg::KIND_RAMP_TARGET: begin
        ramp_goal_next   = sat_value;
        ramp_active_next = (sat_value != last_code);
      end
      dfrc_pkg::KIND_TICK: begin
        if (ramp_active) begin
          // advance one step, clamp at the goal from either side
          if (ramp_diff <= step_eff) begin
            res_code = ramp_goal;
          end else if (ramp_goal > last_code) begin
            res_code = last_code + step_eff;
          end else begin
            res_code = last_code - step_eff;
          end
          last_code_next    = res_code;
          ramp_active_next  = (res_code != ramp_goal);
          powered_down_next = 1'b0;
          res_frame_valid   = 1'b1;
        end
      end
      dfrc_pkg::KIND_POWER_DOWN: begin
        res_frame_valid   = 1'b1;
        res_mode          = dfrc_pkg::MODE_PD_1K;
        powered_down_next = 1'b1;
      end
      dfrc_pkg::KIND_POWER_UP: begin
        res_frame_valid   = 1'b1;
        powered_down_next = 1'b0;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- commit
  always_ff @(posedge clk) begin
    if (rst) begin
      last_code    <= '0;
      ramp_goal    <= '0;
      ramp_active  <= 1'b0;
      powered_down <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == dfrc_pkg::ST_FINISH && out_free) begin
        last_code    <= last_code_next;
        ramp_goal    <= ramp_goal_next;
        ramp_active  <= ramp_active_next;
        powered_down <= powered_down_next;
        out_valid    <= 1'b1;
      end
    end
  end

  // output register payload; frame word is zero when no frame goes out
  always_ff @(posedge clk) begin
    if (state == dfrc_pkg::ST_FINISH && out_free) begin
      frame_valid <= res_frame_valid;
      frame_word  <= res_frame_valid ? {res_mode, res_code, 2'b00} : '0;
      dac_code    <= last_code_next;
      status      <= res_status;
      ramp_busy   <= ramp_active_next;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/dac_frame_ramp_controller_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_frame_ramp_controller_test: self-checking bench of the DAC frame front end
// Drives value, voltage, ramp and power commands with bursty valid and a
// stalling result side. An internal model of the code, ramp and power state
// predicts every result beat, which is checked field by field in order.
// ----------------------------------------------------------------------------
module dac_frame_ramp_controller_test;
  import dfrc_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 20;   // above the divider path latency
  localparam int WATCHDOG_LIMIT  = 2000; // cycles without any accepted beat
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 70;

  typedef struct packed {
    logic        frame_valid;
    logic [15:0] frame_word;
    logic [11:0] dac_code;
    logic        status;
    logic        ramp_busy;
  } dac_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd_kind = '0;
  logic [15:0] cmd_value = '0;
  logic [15:0] cmd_voltage = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        frame_valid;
  logic [15:0] frame_word;
  logic [11:0] dac_code;
  logic        status;
  logic        ramp_busy;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_RAMP_STEP;
  logic [15:0] cfg_data = '0;

  // Model copy of the block state and its registers
  logic [11:0] code_now    = '0;
  logic [11:0] goal_code   = '0;
  logic        ramp_on     = 1'b0;
  logic        pd_on       = 1'b0;
  logic [11:0] step_shadow = RAMP_STEP_RESET;
  logic [15:0] vref_shadow = VREF_RESET;

  dac_result_t awaited_results[$];
  dac_result_t head_result;
  int          error_count = 0;

  // Sender burst bookkeeping; cmd_held marks valid left high across calls
  int          burst_left = 1;
  bit          cmd_held = 1'b0;

  int          ready_tick = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  dac_frame_ramp_controller dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (cmd_kind),
    .value       (cmd_value),
    .voltage     (cmd_voltage),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_valid (frame_valid),
    .frame_word  (frame_word),
    .dac_code    (dac_code),
    .status      (status),
    .ramp_busy   (ramp_busy),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [11:0] saturate_code(input logic [15:0] v);
    return (v > 16'(CODE_MAX)) ? CODE_MAX : v[11:0];
  endfunction

  // Advance the model by one command and return the result beat it causes.
  function automatic dac_result_t predict_response(input logic [2:0]  k,
                                                   input logic [15:0] v,
                                                   input logic [15:0] u);
    dac_result_t r;
    logic [11:0] code;
    logic [11:0] st;
    logic [31:0] scaled;
    bit          write_code;
    r = '0;
    code = '0;
    write_code = 1'b0;
    case (k)
      KIND_SET_VALUE: begin
        code = saturate_code(v);
        write_code = 1'b1;
      end
      KIND_SET_VOLTAGE: begin
        // Reject anything above the reference; zero and full scale map to the
        // end codes directly, so a zero reference never reaches the divide.
        if (u > vref_shadow) begin
          r.status = 1'b1;
        end else begin
          if (u == 16'd0) begin
            code = VMAP_LOW;
          end else if (u == vref_shadow) begin
            code = VMAP_HIGH;
          end else begin
            scaled = (32'(u) * 32'(VMAP_SPAN)) / 32'(vref_shadow);
            code = VMAP_LOW + scaled[11:0];
          end
          write_code = 1'b1;
        end
      end
      KIND_RAMP_TARGET: begin
        goal_code = saturate_code(v);
        ramp_on = (goal_code != code_now);
      end
      KIND_TICK: begin
        if (ramp_on) begin
          // A zero step still moves by one; never pass the goal either way
          st = (step_shadow == 12'd0) ? 12'd1 : step_shadow;
          if (goal_code > code_now) begin
            code_now = (goal_code - code_now <= st) ? goal_code : code_now + st;
          end else begin
            code_now = (code_now - goal_code <= st) ? goal_code : code_now - st;
          end
          if (code_now == goal_code) ramp_on = 1'b0;
          pd_on = 1'b0;
          r.frame_valid = 1'b1;
          r.frame_word = {MODE_NORMAL, code_now, 2'b00};
        end
      end
      KIND_POWER_DOWN: begin
        pd_on = 1'b1;
        r.frame_valid = 1'b1;
        r.frame_word = {MODE_PD_1K, code_now, 2'b00};
      end
      KIND_POWER_UP: begin
        pd_on = 1'b0;
        r.frame_valid = 1'b1;
        r.frame_word = {MODE_NORMAL, code_now, 2'b00};
      end
      default: begin
        // Unused kinds leave the state alone and emit no frame
      end
    endcase
    if (write_code) begin
      // A direct write cancels any ramp and wakes the DAC
      code_now = code;
      ramp_on = 1'b0;
      pd_on = 1'b0;
      r.frame_valid = 1'b1;
      r.frame_word = {MODE_NORMAL, code, 2'b00};
    end
    r.dac_code = code_now;
    r.ramp_busy = ramp_on;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Send one command beat and queue its prediction. Hold valid high into the
  // next call while the burst lasts; drop it and idle when the burst ends.
  task automatic send_command(input logic [2:0] k, input logic [15:0] v,
                              input logic [15:0] u);
    in_valid <= 1'b1;
    cmd_kind <= k;
    cmd_value <= v;
    cmd_voltage <= u;
    cmd_held = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_results.push_back(predict_response(k, v, u));
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      cmd_held = 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      // Mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
    end
  endtask

  // Drop valid, then hold off until every predicted beat has come back.
  task automatic wait_for_results();
    if (cmd_held) begin
      in_valid <= 1'b0;
      cmd_held = 1'b0;
    end
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register while the block is idle and mirror it in the model.
  task automatic write_register(input cfg_index_t idx, input logic [15:0] data);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RAMP_STEP:  step_shadow = data[11:0];
      CFG_VREF_LEVEL: vref_shadow = data;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] random_value();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'(CODE_MAX);
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(4096, 65535));
      default: return 16'($urandom_range(0, 4095));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  // Stall pattern: free-running, random drops, long stalls, and a square wave from
  // bit 1 of the tick counter, each in turn as the tick counter advances.
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case ((ready_tick / 256) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(1, 16);
        end
        default: out_ready <= ready_tick[1];
      endcase
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with no command outstanding, frame %h",
                 $time, frame_word);
        error_count++;
      end else begin
        head_result = awaited_results.pop_front();
        check_field("frame_valid", 16'(head_result.frame_valid), 16'(frame_valid));
        check_field("frame_word", head_result.frame_word, frame_word);
        check_field("dac_code", 16'(head_result.dac_code), 16'(dac_code));
        check_field("status", 16'(head_result.status), 16'(status));
        check_field("ramp_busy", 16'(head_result.ramp_busy), 16'(ramp_busy));
      end
    end
  end

  // Abort when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("dac_frame_ramp_controller test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Direct writes: zero, full scale, and saturation of oversized values.
  task automatic test_set_value();
    send_command(KIND_SET_VALUE, 16'd0, 16'hFFFF);
    send_command(KIND_SET_VALUE, 16'd4095, 16'd0);
    send_command(KIND_SET_VALUE, 16'd4096, 16'h5A5A);
    send_command(KIND_SET_VALUE, 16'hFFFF, 16'hA5A5);
    wait_for_results();
  endtask

  // Voltage map at the reset reference: both ends, rejection, near-end codes.
  task automatic test_set_voltage();
    send_command(KIND_SET_VOLTAGE, 16'hFFFF, 16'd0);
    send_command(KIND_SET_VOLTAGE, 16'd0, VREF_RESET);
    send_command(KIND_SET_VOLTAGE, 16'd0, VREF_RESET + 16'd1);
    send_command(KIND_SET_VOLTAGE, 16'd0, 16'd1);
    send_command(KIND_SET_VOLTAGE, 16'd0, VREF_RESET - 16'd1);
    wait_for_results();
  endtask

  // Downward ramp with clamp at the goal, idle tick, equal target, and a set
  // that cancels an armed ramp.
  task automatic test_ramp();
    send_command(KIND_SET_VALUE, 16'd100, 16'd0);
    send_command(KIND_RAMP_TARGET, 16'd70, 16'd0);
    send_command(KIND_TICK, 16'd0, 16'd0);
    send_command(KIND_TICK, 16'd0, 16'd0);
    send_command(KIND_TICK, 16'd0, 16'd0);
    send_command(KIND_RAMP_TARGET, 16'd70, 16'd0);
    send_command(KIND_RAMP_TARGET, 16'hFFFF, 16'd0);
    send_command(KIND_SET_VALUE, 16'd200, 16'd0);
    send_command(KIND_TICK, 16'd0, 16'd0);
    wait_for_results();
  endtask

  // Power down keeps the code and the ramp; a tick wakes the DAC.
  task automatic test_power();
    send_command(KIND_RAMP_TARGET, 16'd0, 16'd0);
    send_command(KIND_POWER_DOWN, 16'hFFFF, 16'hFFFF);
    send_command(KIND_TICK, 16'd0, 16'd0);
    send_command(KIND_POWER_UP, 16'd0, 16'd0);
    wait_for_results();
  endtask

  task automatic test_unused_kinds();
    send_command(3'd6, 16'd1234, 16'd10);
    send_command(3'd7, 16'hFFFF, 16'hFFFF);
    wait_for_results();
  endtask

  // Zero step moves by one; zero reference accepts only zero volts.
  task automatic test_register_extremes();
    write_register(CFG_RAMP_STEP, 16'd0);
    write_register(CFG_VREF_LEVEL, 16'd0);
    send_command(KIND_SET_VOLTAGE, 16'd0, 16'd0);
    send_command(KIND_SET_VOLTAGE, 16'd0, 16'd1);
    send_command(KIND_RAMP_TARGET, 16'd731, 16'd0);
    send_command(KIND_TICK, 16'd0, 16'd0);
    send_command(KIND_TICK, 16'd0, 16'd0);
    wait_for_results();
  endtask

  // Random traffic: armed ramps followed by mostly ticks, mixed with single
  // commands of every kind and voltages clustered around the reference.
  task automatic run_random_phase(input int items);
    int          sent;
    int          ticks;
    int          target;
    int          reach;
    logic [15:0] volt;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 3) == 0) begin
          target = int'(random_value());
        end else begin
          // Aim near the current code so that ramps often finish
          reach = 6 * ((step_shadow == 12'd0) ? 1 : int'(step_shadow));
          target = int'(code_now) + ($urandom_range(0, 1) ? 1 : -1) *
                   int'($urandom_range(0, reach));
          if (target < 0) target = 0;
          if (target > 65535) target = 65535;
        end
        send_command(KIND_RAMP_TARGET, 16'(target), 16'($urandom()));
        ticks = $urandom_range(1, 8);
        for (int i = 0; i < ticks; i++) begin
          case ($urandom_range(0, 11))
            0: send_command(KIND_POWER_DOWN, 16'($urandom()), 16'($urandom()));
            1: send_command(KIND_SET_VALUE, random_value(), 16'($urandom()));
            2: send_command(KIND_POWER_UP, 16'($urandom()), 16'($urandom()));
            default: send_command(KIND_TICK, 16'($urandom()), 16'($urandom()));
          endcase
        end
        sent += 1 + ticks;
      end else begin
        case ($urandom_range(0, 4))
          0: volt = 16'd0;
          1: volt = vref_shadow;
          2: volt = (vref_shadow == 16'hFFFF) ? vref_shadow : vref_shadow + 16'd1;
          3: volt = 16'($urandom());
          default: volt = 16'($urandom_range(0, int'(vref_shadow)));
        endcase
        send_command(3'($urandom_range(0, 7)), random_value(), volt);
        sent++;
      end
    end
  endtask

  // Walk through register settings, extremes first, then random ones, reset values last.
  task automatic test_random();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          write_register(CFG_RAMP_STEP, 16'hFFFF);
          write_register(CFG_VREF_LEVEL, 16'hFFFF);
        end
        1: begin
          write_register(CFG_RAMP_STEP, 16'd1);
          write_register(CFG_VREF_LEVEL, 16'd1);
        end
        2: begin
          write_register(CFG_RAMP_STEP, 16'($urandom_range(1, 64)));
          write_register(CFG_VREF_LEVEL, 16'($urandom_range(1, 65535)));
        end
        3: begin
          write_register(CFG_RAMP_STEP, 16'($urandom_range(1, 4095)));
          write_register(CFG_VREF_LEVEL, 16'($urandom_range(0, 5000)));
        end
        4: begin
          write_register(CFG_RAMP_STEP, 16'($urandom()));
          write_register(CFG_VREF_LEVEL, 16'($urandom()));
        end
        default: begin
          write_register(CFG_RAMP_STEP, 16'(RAMP_STEP_RESET));
          write_register(CFG_VREF_LEVEL, VREF_RESET);
        end
      endcase
      run_random_phase(ITEMS_PER_PHASE);
      wait_for_results();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_set_value();
    test_set_voltage();
    test_ramp();
    test_power();
    test_unused_kinds();
    test_register_extremes();
    test_random();
    wait_for_results();
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("dac_frame_ramp_controller test passed");
    end else begin
      $display("dac_frame_ramp_controller test failed");
    end
    $finish;
  end

endmodule
